>>> rtl/mvdp_pkg.sv
// Shared types and constants for the meshlet vertex dedup packer.
package mvdp_pkg;

   localparam int VERTEX_W = 32;
   localparam int CORNERS = 3;
   localparam int MAX_VERTS_W = 7;
   localparam int MAX_PRIMS_W = 9;
   localparam int LOCAL_W = 6;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 9;
   localparam int DEFAULT_VERT_SLOTS = 64;

   localparam logic [MAX_VERTS_W-1:0] MAX_VERTS_RESET = 7'd64;
   localparam logic [MAX_PRIMS_W-1:0] MAX_PRIMS_RESET = 9'd64;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_VERTS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PRIMS = 1'b1;

   typedef struct packed {
      logic                              valid;
      logic [CORNERS-1:0][VERTEX_W-1:0]  corner;
   } token_type;

endpackage

>>> rtl/meshlet_vertex_dedup_packer_core.sv
// Top level of the meshlet vertex dedup packer: control, counters and the slot chain.
//
// A triangle (three global vertex indices and a start_new flag) is taken on the
// req_ channel; each transfer yields exactly one result on the rsp_ channel with
// the accepted flag, the local slot of each corner, the vertex and triangle
// counts and the meshlet_full flag. Limits are to be written on the csr_ port only
// while the block is idle; the block does not enforce it. csr_ready is always high.
// The triangle travels down a chain of VERT_SLOTS cells, one cell per cycle,
// and each cell compares its stored vertex with the three corners. The result
// at the chain tail is captured in found_ff and slot_ff, then the response is
// written to the output register, and the next triangle can be taken once
// the block is back in the idle state.
// One triangle is in work at a time; req_stall is high while it is.
// A finished result sits in an output register; if rsp_stall holds it, the next
// triangle is still taken and searched, and waits for the register to free.
// Reset clears the counters, the chain and the output valid and restores both
// limits to 64. Slot contents are not cleared; only slots below the vertex
// count are ever matched.
module meshlet_vertex_dedup_packer_core
   import mvdp_pkg::*;
#(
   parameter int VERT_SLOTS = DEFAULT_VERT_SLOTS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [VERTEX_W-1:0]      req_vertex_a,
   input  logic [VERTEX_W-1:0]      req_vertex_b,
   input  logic [VERTEX_W-1:0]      req_vertex_c,
   input  logic                     req_start_new,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_accepted,
   output logic [LOCAL_W-1:0]       rsp_local_a,
   output logic [LOCAL_W-1:0]       rsp_local_b,
   output logic [LOCAL_W-1:0]       rsp_local_c,
   output logic [MAX_VERTS_W-1:0]   rsp_vertex_count,
   output logic [MAX_PRIMS_W-1:0]   rsp_prim_count,
   output logic                     rsp_meshlet_full,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SLOT_W = $clog2(VERT_SLOTS);
   localparam int CNT_W = $clog2(VERT_SLOTS + 1);
   localparam int CMP_W = (CNT_W > MAX_VERTS_W) ? CNT_W + 1 : MAX_VERTS_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type                       state_ff;
   logic [MAX_VERTS_W-1:0]          max_verts_ff;
   logic [MAX_PRIMS_W-1:0]          max_prims_ff;
   logic [CNT_W-1:0]                used_ff;
   logic [MAX_PRIMS_W-1:0]          tri_ff;
   logic                            inject_ff;
   token_type                       cur_ff;
   token_type                       head_tok;
   logic [CORNERS-1:0]              found_ff;
   logic [CORNERS-1:0][SLOT_W-1:0]  slot_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_accepted_ff;
   logic [LOCAL_W-1:0]              rsp_local_a_ff;
   logic [LOCAL_W-1:0]              rsp_local_b_ff;
   logic [LOCAL_W-1:0]              rsp_local_c_ff;
   logic [MAX_VERTS_W-1:0]          rsp_vertex_count_ff;
   logic [MAX_PRIMS_W-1:0]          rsp_prim_count_ff;
   logic                            rsp_meshlet_full_ff;

   token_type                       tok_chain [VERT_SLOTS+1];
   logic [CORNERS-1:0]              found_chain [VERT_SLOTS+1];
   logic [CORNERS-1:0][SLOT_W-1:0]  slot_chain [VERT_SLOTS+1];

   logic                            req_take;
   logic                            out_free;
   logic                            finish;
   logic [CMP_W-1:0]                vert_limit;
   logic [1:0]                      fresh;
   logic [CMP_W-1:0]                used_sum;
   logic                            ok;
   logic [CNT_W-1:0]                used_in;
   logic [MAX_PRIMS_W-1:0]          tri_in;
   logic                            full;
   logic [CORNERS-1:0]              wr_new;
   logic [CORNERS-1:0][SLOT_W-1:0]  wr_slot;
   logic [CORNERS-1:0][SLOT_W-1:0]  final_slot;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish = (state_ff == ST_DONE) && out_free;

   assign head_tok.valid = inject_ff;
   assign head_tok.corner = cur_ff.corner;
   assign tok_chain[0] = head_tok;
   assign found_chain[0] = '0;
   assign slot_chain[0] = '0;

   for (genvar i = 0; i < VERT_SLOTS; i++) begin : g_cell
      mvdp_cell #(
         .VERT_SLOTS (VERT_SLOTS),
         .IDX        (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .used      (used_ff),
         .tok_in    (tok_chain[i]),
         .found_in  (found_chain[i]),
         .slot_in   (slot_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .found_out (found_chain[i+1]),
         .slot_out  (slot_chain[i+1]),
         .wr_en     (finish && ok),
         .wr_new    (wr_new),
         .wr_slot   (wr_slot),
         .wr_tok    (cur_ff)
      );
   end

   always_comb begin
      vert_limit = (CMP_W'(max_verts_ff) > CMP_W'(VERT_SLOTS)) ?
                   CMP_W'(VERT_SLOTS) : CMP_W'(max_verts_ff);
      fresh = 2'(!found_ff[0]) + 2'(!found_ff[1]) + 2'(!found_ff[2]);
      used_sum = CMP_W'(used_ff) + CMP_W'(fresh);
      ok = (CMP_W'(used_ff) < vert_limit) && (tri_ff < max_prims_ff) &&
           (used_sum <= vert_limit);
      wr_new = ~found_ff;
      wr_slot[0] = SLOT_W'(used_ff);
      wr_slot[1] = SLOT_W'(used_ff + CNT_W'(!found_ff[0]));
      wr_slot[2] = SLOT_W'(used_ff + CNT_W'(!found_ff[0]) + CNT_W'(!found_ff[1]));
      for (int j = 0; j < CORNERS; j++) begin
         final_slot[j] = found_ff[j] ? slot_ff[j] : wr_slot[j];
      end
      used_in = CNT_W'(used_sum);
      tri_in = tri_ff + MAX_PRIMS_W'(1);
      full = (used_sum >= vert_limit) || (tri_in >= max_prims_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_verts_ff <= MAX_VERTS_RESET;
         max_prims_ff <= MAX_PRIMS_RESET;
         used_ff <= '0;
         tri_ff <= '0;
         inject_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inject_ff <= req_take;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MAX_VERTS: max_verts_ff <= csr_wdata[MAX_VERTS_W-1:0];
               REG_MAX_PRIMS: max_prims_ff <= csr_wdata[MAX_PRIMS_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (req_start_new) begin
                     used_ff <= '0;
                     tri_ff <= '0;
                  end
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (tok_chain[VERT_SLOTS].valid) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  if (ok) begin
                     used_ff <= full ? '0 : used_in;
                     tri_ff <= full ? '0 : tri_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cur_ff.valid <= 1'b1;
         cur_ff.corner[0] <= req_vertex_a;
         cur_ff.corner[1] <= req_vertex_b;
         cur_ff.corner[2] <= req_vertex_c;
      end
      if (state_ff == ST_SEARCH && tok_chain[VERT_SLOTS].valid) begin
         found_ff <= found_chain[VERT_SLOTS];
         slot_ff <= slot_chain[VERT_SLOTS];
      end
      if (finish) begin
         rsp_accepted_ff <= ok;
         rsp_local_a_ff <= ok ? LOCAL_W'(final_slot[0]) : '0;
         rsp_local_b_ff <= ok ? LOCAL_W'(final_slot[1]) : '0;
         rsp_local_c_ff <= ok ? LOCAL_W'(final_slot[2]) : '0;
         rsp_vertex_count_ff <= ok ? MAX_VERTS_W'(used_in) : MAX_VERTS_W'(used_ff);
         rsp_prim_count_ff <= ok ? tri_in : tri_ff;
         rsp_meshlet_full_ff <= ok && full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_local_a = rsp_local_a_ff;
   assign rsp_local_b = rsp_local_b_ff;
   assign rsp_local_c = rsp_local_c_ff;
   assign rsp_vertex_count = rsp_vertex_count_ff;
   assign rsp_prim_count = rsp_prim_count_ff;
   assign rsp_meshlet_full = rsp_meshlet_full_ff;

   a_tail_only_in_search: assert property (@(posedge clock) disable iff (reset)
      tok_chain[VERT_SLOTS].valid |-> state_ff == ST_SEARCH)
      else $error("search token left the chain outside the search state");

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(used_ff) <= CMP_W'(VERT_SLOTS))
      else $error("vertex count exceeds the slot count");

   a_full_clears: assert property (@(posedge clock) disable iff (reset)
      finish && ok && full |=> used_ff == '0 && tri_ff == '0)
      else $error("full meshlet was not cleared");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      finish && !ok |=> $stable(used_ff) && $stable(tri_ff))
      else $error("rejected triangle changed the meshlet");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      inject_ff |-> state_ff == ST_SEARCH)
      else $error("triangle injected outside the search state");

endmodule

>>> rtl/mvdp_cell.sv
// One vertex slot of the dedup chain: stores a vertex and matches passing triangles.
module mvdp_cell
   import mvdp_pkg::*;
#(
   parameter int VERT_SLOTS = DEFAULT_VERT_SLOTS,
   parameter int IDX = 0,
   localparam int SLOT_W = $clog2(VERT_SLOTS),
   localparam int CNT_W = $clog2(VERT_SLOTS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [CNT_W-1:0]                used,
   input  token_type                       tok_in,
   input  logic [CORNERS-1:0]              found_in,
   input  logic [CORNERS-1:0][SLOT_W-1:0]  slot_in,
   output token_type                       tok_out,
   output logic [CORNERS-1:0]              found_out,
   output logic [CORNERS-1:0][SLOT_W-1:0]  slot_out,
   input  logic                            wr_en,
   input  logic [CORNERS-1:0]              wr_new,
   input  logic [CORNERS-1:0][SLOT_W-1:0]  wr_slot,
   input  token_type                       wr_tok
);

   logic [VERTEX_W-1:0]             vert_ff;
   logic                            tok_valid_ff;
   logic [CORNERS-1:0][VERTEX_W-1:0] tok_corner_ff;
   logic [CORNERS-1:0]              found_ff;
   logic [CORNERS-1:0]              found_in_next;
   logic [CORNERS-1:0][SLOT_W-1:0]  slot_ff;
   logic [CORNERS-1:0][SLOT_W-1:0]  slot_in_next;
   logic                            live;

   assign live = tok_in.valid && (used > CNT_W'(IDX));

   always_comb begin
      found_in_next = found_in;
      slot_in_next = slot_in;
      for (int j = 0; j < CORNERS; j++) begin
         if (live && (vert_ff == tok_in.corner[j])) begin
            found_in_next[j] = 1'b1;
            slot_in_next[j] = SLOT_W'(IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_in.valid;
      end
      tok_corner_ff <= tok_in.corner;
      found_ff <= found_in_next;
      slot_ff <= slot_in_next;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int j = 0; j < CORNERS; j++) begin
            if (wr_new[j] && (wr_slot[j] == SLOT_W'(IDX))) begin
               vert_ff <= wr_tok.corner[j];
            end
         end
      end
   end

   assign tok_out.valid = tok_valid_ff;
   assign tok_out.corner = tok_corner_ff;
   assign found_out = found_ff;
   assign slot_out = slot_ff;

endmodule
